FILE: sv/rsvy_pkg.sv
// Shared types and constants for the RC stick to velocity and yaw command block.
package rsvy_pkg;

  localparam int unsigned InTdataW  = 136;
  localparam int unsigned OutTdataW = 80;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [StatusW-1:0] ST_COMMAND         = 3'd0;
  localparam logic [StatusW-1:0] ST_NO_BASE         = 3'd1;
  localparam logic [StatusW-1:0] ST_TOGGLE_AT_START = 3'd2;
  localparam logic [StatusW-1:0] ST_SHUTDOWN        = 3'd3;
  localparam logic [StatusW-1:0] ST_BASE_STORED     = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_MAX_HOR  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_VER  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_YAW  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEAD_ZONE = 2'd3;

  localparam logic [14:0] RST_MAX_HOR   = 15'd512;
  localparam logic [14:0] RST_MAX_VER   = 15'd256;
  localparam logic [15:0] RST_MAX_YAW   = 16'd4096;
  localparam logic [13:0] RST_DEAD_ZONE = 14'd1638;

  typedef struct packed {
    logic [14:0] max_horizontal_speed;
    logic [14:0] max_vertical_speed;
    logic [15:0] max_yaw_rate;
    logic [13:0] dead_zone_half_width;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] current_yaw;
    logic        toggle_on;
    logic [15:0] pitch_stick;
    logic [15:0] roll_stick;
    logic [15:0] yaw_stick;
    logic [15:0] thrust_stick;
    logic [31:0] time_now;
  } item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [15:0]        vel_forward;
    logic [15:0]        vel_lateral;
    logic [15:0]        vel_up;
    logic [31:0]        yaw_target;
  } res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

endpackage

FILE: sv/rsvy_sermul.sv
// Bit-serial shift-add multiplier, 32 by 32 bits unsigned, one multiplier bit per cycle.
module rsvy_sermul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic [63:0] p_q, p_d;
  logic [31:0] a_q, a_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] sum;

  always_comb begin
    sum    = {1'b0, p_q[63:32]} + (p_q[0] ? {1'b0, a_q} : 33'd0);
    p_d    = p_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      p_d    = {32'd0, b_i};
      a_d    = a_i;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {sum, p_q[31:1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 5'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

FILE: sv/rsvy_core.sv
// Item sequencer: arming state, stick operands, product scheduling, rounding and yaw saturation.
module rsvy_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rsvy_pkg::cfg_t          cfg_i,
  input  logic                    accept_i,
  input  rsvy_pkg::item_t         item_i,
  input  logic                    res_ready_i,
  output rsvy_pkg::core_stat_t    stat_o,
  output rsvy_pkg::res_t          res_o
);
  import rsvy_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_MUL   = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  localparam logic [2:0] K_PITCH  = 3'd0;
  localparam logic [2:0] K_ROLL   = 3'd1;
  localparam logic [2:0] K_THRUST = 3'd2;
  localparam logic [2:0] K_RATE   = 3'd3;
  localparam logic [2:0] K_DT     = 3'd4;

  function automatic logic [15:0] mag16(input logic [15:0] s);
    return s[15] ? (~s + 16'd1) : s;
  endfunction

  function automatic logic in_dz(input logic [15:0] s, input logic [13:0] h);
    logic signed [16:0] sv;
    logic signed [16:0] hv;
    sv = {s[15], s};
    hv = {3'd0, h};
    return (sv >= -hv) && (sv <= hv);
  endfunction

  state_e      state_q, state_d;
  logic [2:0]  k_q, k_d;
  logic        base_seen_q, base_seen_d;
  logic        rc_seen_q, rc_seen_d;
  logic        armed_q, armed_d;
  logic [31:0] stored_yaw_q, stored_yaw_d;
  logic [31:0] yaw_cmd_q, yaw_cmd_d;
  logic [31:0] last_time_q, last_time_d;

  logic [15:0] mag_p_q, mag_p_d, mag_r_q, mag_r_d, mag_y_q, mag_y_d, thrust_q, thrust_d;
  logic [31:0] dt_q, dt_d, m1_q, m1_d;
  logic [2:0]  neg_q, neg_d, dz_q, dz_d;
  res_t        res_q, res_d;

  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [18:0] r15_sum;
  logic [17:0] r15;
  logic [17:0] up_diff;
  logic [34:0] r31_sum;
  logic [33:0] r31;
  logic [34:0] inc, acc;
  logic [31:0] yaw_sat;

  rsvy_sermul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  always_comb begin
    case (k_q)
      K_PITCH: begin
        mul_a = {16'd0, mag_p_q};
        mul_b = {17'd0, cfg_i.max_horizontal_speed};
      end
      K_ROLL: begin
        mul_a = {16'd0, mag_r_q};
        mul_b = {17'd0, cfg_i.max_horizontal_speed};
      end
      K_THRUST: begin
        mul_a = {16'd0, thrust_q};
        mul_b = {17'd0, cfg_i.max_vertical_speed};
      end
      K_RATE: begin
        mul_a = {16'd0, mag_y_q};
        mul_b = {16'd0, cfg_i.max_yaw_rate};
      end
      default: begin
        mul_a = m1_q;
        mul_b = dt_q;
      end
    endcase
  end

  always_comb begin
    r15_sum = {1'b0, prod[31:14]} + 19'd1;
    r15     = r15_sum[18:1];
    up_diff = {1'b0, r15[16:0]} - {3'd0, cfg_i.max_vertical_speed};
    r31_sum = {1'b0, prod[63:30]} + 35'd1;
    r31     = r31_sum[34:1];
    if (dz_q[2]) begin
      inc = 35'd0;
    end else if (neg_q[2]) begin
      inc = ~{1'b0, r31} + 35'd1;
    end else begin
      inc = {1'b0, r31};
    end
    acc = {{3{yaw_cmd_q[31]}}, yaw_cmd_q} + inc;
    if (acc[34] && (acc[33:31] != 3'b111)) begin
      yaw_sat = 32'h8000_0000;
    end else if (!acc[34] && (acc[33:31] != 3'b000)) begin
      yaw_sat = 32'h7FFF_FFFF;
    end else begin
      yaw_sat = acc[31:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    base_seen_d  = base_seen_q;
    rc_seen_d    = rc_seen_q;
    armed_d      = armed_q;
    stored_yaw_d = stored_yaw_q;
    yaw_cmd_d    = yaw_cmd_q;
    last_time_d  = last_time_q;
    mag_p_d      = mag_p_q;
    mag_r_d      = mag_r_q;
    mag_y_d      = mag_y_q;
    thrust_d     = thrust_q;
    dt_d         = dt_q;
    m1_d         = m1_q;
    neg_d        = neg_q;
    dz_d         = dz_q;
    res_d        = res_q;
    mul_start    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          res_d   = '0;
          state_d = S_FIN;
          if (!item_i.command) begin
            stored_yaw_d = item_i.current_yaw;
            base_seen_d  = 1'b1;
            res_d.status = ST_BASE_STORED;
          end else if (!base_seen_q) begin
            res_d.status = ST_NO_BASE;
          end else if (!rc_seen_q && item_i.toggle_on) begin
            res_d.status = ST_TOGGLE_AT_START;
          end else if (armed_q && !item_i.toggle_on) begin
            res_d.status = ST_SHUTDOWN;
          end else begin
            rc_seen_d = 1'b1;
            if (!armed_q && item_i.toggle_on) begin
              armed_d   = 1'b1;
              yaw_cmd_d = stored_yaw_q;
              dt_d      = 32'd0;
            end else begin
              dt_d = item_i.time_now - last_time_q;
            end
            last_time_d  = item_i.time_now;
            mag_p_d      = mag16(item_i.pitch_stick);
            mag_r_d      = mag16(item_i.roll_stick);
            mag_y_d      = mag16(item_i.yaw_stick);
            thrust_d     = item_i.thrust_stick;
            neg_d        = {item_i.yaw_stick[15], item_i.roll_stick[15], item_i.pitch_stick[15]};
            dz_d         = {in_dz(item_i.yaw_stick, cfg_i.dead_zone_half_width),
                            in_dz(item_i.roll_stick, cfg_i.dead_zone_half_width),
                            in_dz(item_i.pitch_stick, cfg_i.dead_zone_half_width)};
            k_d          = K_PITCH;
            res_d.status = ST_COMMAND;
            state_d      = S_START;
          end
        end
      end
      S_START: begin
        mul_start = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          k_d     = k_q + 3'd1;
          state_d = S_START;
          case (k_q)
            K_PITCH: begin
              res_d.vel_forward = dz_q[0] ? 16'd0
                                 : (neg_q[0] ? (~r15[15:0] + 16'd1) : r15[15:0]);
            end
            K_ROLL: begin
              res_d.vel_lateral = dz_q[1] ? 16'd0
                                 : (neg_q[1] ? r15[15:0] : (~r15[15:0] + 16'd1));
            end
            K_THRUST: begin
              res_d.vel_up = up_diff[15:0];
            end
            K_RATE: begin
              m1_d = prod[31:0];
            end
            default: begin
              yaw_cmd_d        = yaw_sat;
              res_d.yaw_target = yaw_sat;
              state_d          = S_FIN;
            end
          endcase
        end
      end
      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      k_q          <= K_PITCH;
      base_seen_q  <= 1'b0;
      rc_seen_q    <= 1'b0;
      armed_q      <= 1'b0;
      stored_yaw_q <= 32'd0;
      yaw_cmd_q    <= 32'd0;
      last_time_q  <= 32'd0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      base_seen_q  <= base_seen_d;
      rc_seen_q    <= rc_seen_d;
      armed_q      <= armed_d;
      stored_yaw_q <= stored_yaw_d;
      yaw_cmd_q    <= yaw_cmd_d;
      last_time_q  <= last_time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_p_q  <= mag_p_d;
    mag_r_q  <= mag_r_d;
    mag_y_q  <= mag_y_d;
    thrust_q <= thrust_d;
    dt_q     <= dt_d;
    m1_q     <= m1_d;
    neg_q    <= neg_d;
    dz_q     <= dz_d;
    res_q    <= res_d;
  end

  assign stat_o.idle      = (state_q == S_IDLE);
  assign stat_o.res_valid = (state_q == S_FIN);
  assign res_o            = res_q;

endmodule

FILE: sv/rc_stick_to_velocity_yaw_command_top.sv
// Top level of the RC stick to velocity and yaw command block.
//
// Slave stream: one word per base-state update (tuser = 0) or RC frame (tuser = 1).
// Master stream: one word per accepted input word, status in tuser, commands in tdata.
// Config channel: cfg_index_i selects max horizontal speed, max vertical speed,
// max yaw rate or dead zone half width; always ready, write only while idle.
// Timing: base updates and rejected frames (no base, toggle on at start,
// shutdown) are registered in the sequencer, then move into the output register
// once it is free. A frame that issues a command runs five products through one
// bit-serial 32x32 multiplier (pitch, roll, thrust, stick times yaw rate, that
// times elapsed ticks), one after another, before its result moves the same way.
// Flow: one word at a time; the next word is taken as soon as the result
// sits in the output register, even if the receiver has not taken it yet.
// Stall: a held result blocks the sequencer in its final step until the
// output register frees up; s_axis_tready stays low meanwhile.
// Reset: clears arming state, stored yaw, yaw target and elapsed-time base,
// loads default config values, and empties the output register.
module rc_stick_to_velocity_yaw_command_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // current_yaw, toggle_on, pitch_stick, roll_stick, yaw_stick, thrust_stick,
  // time_now, zero pad
  input  logic [rsvy_pkg::InTdataW-1:0]         s_axis_tdata,
  // command
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // vel_forward, vel_lateral, vel_up, yaw_target
  output logic [rsvy_pkg::OutTdataW-1:0]        m_axis_tdata,
  // status
  output logic [rsvy_pkg::StatusW-1:0]          m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rsvy_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [rsvy_pkg::CfgDataW-1:0]         cfg_data_i
);
  import rsvy_pkg::*;

  cfg_t       cfg_q, cfg_d;
  item_t      item;
  core_stat_t stat;
  res_t       res;
  res_t       out_q;
  logic       out_valid_q, out_valid_d;
  logic       accept, res_ready;

  assign item.command      = s_axis_tuser;
  assign item.current_yaw  = s_axis_tdata[31:0];
  assign item.toggle_on    = s_axis_tdata[32];
  assign item.pitch_stick  = s_axis_tdata[48:33];
  assign item.roll_stick   = s_axis_tdata[64:49];
  assign item.yaw_stick    = s_axis_tdata[80:65];
  assign item.thrust_stick = s_axis_tdata[96:81];
  assign item.time_now     = s_axis_tdata[128:97];

  assign s_axis_tready = stat.idle;
  assign accept        = s_axis_tvalid && stat.idle;
  assign res_ready     = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  rsvy_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .item_i      (item),
    .res_ready_i (res_ready),
    .stat_o      (stat),
    .res_o       (res)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_HOR:   cfg_d.max_horizontal_speed = cfg_data_i[14:0];
        CFG_MAX_VER:   cfg_d.max_vertical_speed   = cfg_data_i[14:0];
        CFG_MAX_YAW:   cfg_d.max_yaw_rate         = cfg_data_i;
        CFG_DEAD_ZONE: cfg_d.dead_zone_half_width = cfg_data_i[13:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (stat.res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_horizontal_speed <= RST_MAX_HOR;
      cfg_q.max_vertical_speed   <= RST_MAX_VER;
      cfg_q.max_yaw_rate         <= RST_MAX_YAW;
      cfg_q.dead_zone_half_width <= RST_DEAD_ZONE;
      out_valid_q                <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.yaw_target, out_q.vel_up, out_q.vel_lateral, out_q.vel_forward};

endmodule

FILE: sv/rsvy_chk.sv
// Port-level checker for the RC stick to velocity and yaw command block, with its bind.
module rsvy_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [rsvy_pkg::OutTdataW-1:0]      m_axis_tdata,
  input logic [rsvy_pkg::StatusW-1:0]        m_axis_tuser
);
  import rsvy_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_COMMAND) || (m_axis_tuser == ST_NO_BASE)
      || (m_axis_tuser == ST_TOGGLE_AT_START) || (m_axis_tuser == ST_SHUTDOWN)
      || (m_axis_tuser == ST_BASE_STORED))
    else $error("status code out of range");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_COMMAND) |-> m_axis_tdata == '0)
    else $error("non-command status with nonzero payload");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous word still in work");

endmodule

bind rc_stick_to_velocity_yaw_command_top rsvy_chk u_rsvy_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: sim/rc_stick_to_velocity_yaw_command_top_tb.sv
// Testbench for the RC stick to velocity and yaw command block: directed and random stream traffic.
`timescale 1ns / 100ps

module rc_stick_to_velocity_yaw_command_top_tb;
  import rsvy_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int PhaseWords = 180;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InTdataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [StatusW-1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  item_t words_to_send[$];
  res_t commands_due[$];
  item_t word_in_flight = '0;
  logic word_taken = 1'b0;
  int send_idle_pct = 32;
  int recv_idle_pct = 54;
  int fail_count = 0;
  int quiet_cycles = 0;
  logic [31:0] tick_gen = '0;

  cfg_t cfg = '{RST_MAX_HOR, RST_MAX_VER, RST_MAX_YAW, RST_DEAD_ZONE};
  logic base_known = 1'b0;
  logic frames_started = 1'b0;
  logic armed_q = 1'b0;
  logic signed [31:0] held_yaw = '0;
  logic signed [31:0] yaw_goal = '0;
  logic [31:0] prev_tick = '0;

  rc_stick_to_velocity_yaw_command_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint round_scaled(longint prod, int unsigned sh);
    bit [63:0] mag;
    bit neg;
    neg = prod < 0;
    mag = neg ? 64'(-prod) : 64'(prod);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic bit in_dead_band(logic signed [15:0] s);
    int h;
    h = int'(cfg.dead_zone_half_width);
    return int'(s) >= -h && int'(s) <= h;
  endfunction

  function automatic res_t compute_command(item_t w);
    res_t r;
    longint hor;
    longint ver;
    longint inc;
    longint acc;
    logic [31:0] dt;
    logic signed [15:0] p;
    logic signed [15:0] rl;
    logic signed [15:0] ys;
    r = '0;
    p = w.pitch_stick;
    rl = w.roll_stick;
    ys = w.yaw_stick;
    hor = longint'(cfg.max_horizontal_speed);
    ver = longint'(cfg.max_vertical_speed);
    if (!w.command) begin
      held_yaw = w.current_yaw;
      base_known = 1'b1;
      r.status = ST_BASE_STORED;
      return r;
    end
    if (!base_known) begin
      r.status = ST_NO_BASE;
      return r;
    end
    if (!frames_started) begin
      if (w.toggle_on) begin
        r.status = ST_TOGGLE_AT_START;
        return r;
      end
      frames_started = 1'b1;
    end
    if (!armed_q && w.toggle_on) begin
      armed_q = 1'b1;
      prev_tick = w.time_now;
      yaw_goal = held_yaw;
    end else if (armed_q && !w.toggle_on) begin
      r.status = ST_SHUTDOWN;
      return r;
    end
    r.status = ST_COMMAND;
    r.vel_forward = in_dead_band(p) ? '0 : 16'(round_scaled(longint'(p) * hor, 15));
    r.vel_lateral = in_dead_band(rl) ? '0 : 16'(-round_scaled(longint'(rl) * hor, 15));
    r.vel_up = 16'(round_scaled(longint'(w.thrust_stick) * ver, 15) - ver);
    dt = w.time_now - prev_tick;
    prev_tick = w.time_now;
    inc = 0;
    if (!in_dead_band(ys)) begin
      inc = round_scaled(longint'(ys) * longint'(cfg.max_yaw_rate) * longint'(dt), 31);
    end
    acc = longint'(yaw_goal) + inc;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    yaw_goal = 32'(acc);
    r.yaw_target = yaw_goal;
    return r;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    case (idx)
      CFG_MAX_HOR: cfg.max_horizontal_speed = val[14:0];
      CFG_MAX_VER: cfg.max_vertical_speed = val[14:0];
      CFG_MAX_YAW: cfg.max_yaw_rate = val[15:0];
      CFG_DEAD_ZONE: cfg.dead_zone_half_width = val[13:0];
      default: ;
    endcase
  endfunction

  function automatic item_t frame(logic cmd, logic [31:0] yaw, logic tog, logic [15:0] p,
                                  logic [15:0] rl, logic [15:0] ys, logic [15:0] th,
                                  logic [31:0] t);
    item_t w;
    w.command = cmd;
    w.current_yaw = yaw;
    w.toggle_on = tog;
    w.pitch_stick = p;
    w.roll_stick = rl;
    w.yaw_stick = ys;
    w.thrust_stick = th;
    w.time_now = t;
    return w;
  endfunction

  function automatic logic [15:0] stick_value();
    logic [15:0] edge_val;
    edge_val = 16'(cfg.dead_zone_half_width) + 16'($urandom_range(0, 1));
    if ($urandom_range(0, 1) == 1) edge_val = -edge_val;
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return edge_val;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t random_word();
    item_t w;
    int kind;
    kind = $urandom_range(0, 99);
    w.command = kind >= 12;
    w.current_yaw = $urandom;
    w.toggle_on = w.command ? (kind >= 27) : 1'($urandom_range(0, 1));
    w.pitch_stick = stick_value();
    w.roll_stick = stick_value();
    w.yaw_stick = stick_value();
    case ($urandom_range(0, 5))
      0: w.thrust_stick = 16'h0000;
      1: w.thrust_stick = 16'hFFFF;
      default: w.thrust_stick = 16'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) tick_gen = $urandom;
    else tick_gen = tick_gen + 32'($urandom_range(0, 20000));
    w.time_now = tick_gen;
    return w;
  endfunction

  always @(negedge clk_i) begin : driver
    item_t nxt;
    m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
    if (!s_axis_tvalid || word_taken) begin
      if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = words_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= nxt.command;
        s_axis_tdata <= {7'b0, nxt.time_now, nxt.thrust_stick, nxt.yaw_stick,
                         nxt.roll_stick, nxt.pitch_stick, nxt.toggle_on, nxt.current_yaw};
        word_in_flight <= nxt;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    res_t due;
    bit busy;
    busy = 1'b0;
    word_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      commands_due.push_back(compute_command(word_in_flight));
      busy = 1'b1;
    end
    if (cfg_valid_i && cfg_ready_o) begin
      apply_reg(cfg_index_i, cfg_data_i);
      busy = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      busy = 1'b1;
      if (commands_due.size() == 0) begin
        $error("unexpected result word, status %0d", m_axis_tuser);
        fail_count++;
      end else begin
        due = commands_due.pop_front();
        if (m_axis_tuser !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[15:0] !== due.vel_forward) begin
          $error("vel_forward: expected %0d, actual %0d", $signed(due.vel_forward),
                 $signed(m_axis_tdata[15:0]));
          fail_count++;
        end
        if (m_axis_tdata[31:16] !== due.vel_lateral) begin
          $error("vel_lateral: expected %0d, actual %0d", $signed(due.vel_lateral),
                 $signed(m_axis_tdata[31:16]));
          fail_count++;
        end
        if (m_axis_tdata[47:32] !== due.vel_up) begin
          $error("vel_up: expected %0d, actual %0d", $signed(due.vel_up),
                 $signed(m_axis_tdata[47:32]));
          fail_count++;
        end
        if (m_axis_tdata[79:48] !== due.yaw_target) begin
          $error("yaw_target: expected %0d, actual %0d", $signed(due.yaw_target),
                 $signed(m_axis_tdata[79:48]));
          fail_count++;
        end
      end
    end
    if (!rst_ni || busy) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(int hor, int ver, int rate, int dz);
    write_reg(CFG_MAX_HOR, 16'(hor));
    write_reg(CFG_MAX_VER, 16'(ver));
    write_reg(CFG_MAX_YAW, 16'(rate));
    write_reg(CFG_DEAD_ZONE, 16'(dz));
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (words_to_send.size() != 0 || s_axis_tvalid || commands_due.size() != 0);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    words_to_send.push_back(frame(1, 0, 1, 0, 0, 0, 0, 10));
    words_to_send.push_back(frame(1, 0, 0, 5000, 5000, 5000, 5000, 20));
    words_to_send.push_back(frame(0, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    words_to_send.push_back(frame(1, 0, 1, 100, 100, 100, 100, 30));
    words_to_send.push_back(frame(1, 0, 0, 16'h8000, 16'h7FFF, 0, 0, 100));
    words_to_send.push_back(frame(1, 0, 0, 1638, -16'sd1638, 1638, 16'hFFFF, 200));
    words_to_send.push_back(frame(1, 0, 0, 1639, -16'sd1639, -16'sd1639, 16'h8000,
                                  32'h8000_0000));
    words_to_send.push_back(frame(1, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 50));
    wait_drained();
    write_reg(CFG_MAX_YAW, 16'hFFFF);
    words_to_send.push_back(frame(1, 0, 0, 0, 0, 16'h8000, 16'hFFFF, 49));
    words_to_send.push_back(frame(0, 32'h7FFF_0000, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 32'hFFFF_FFFF));
    words_to_send.push_back(frame(1, 0, 1, 0, 0, 16'h7FFF, 0, 32'hFFFF_FF00));
    words_to_send.push_back(frame(1, 0, 1, 0, 0, 16'h7FFF, 0, 32'h0000_0100));
    words_to_send.push_back(frame(1, 0, 1, 0, 0, 16'h7FFF, 0, 32'h7FFF_0000));
    words_to_send.push_back(frame(1, 0, 0, 0, 0, 0, 0, 1000));
    words_to_send.push_back(frame(1, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 2000));
    words_to_send.push_back(frame(0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
    words_to_send.push_back(frame(1, 0, 1, -16'sd20000, 30000, 16'h8000, 16'hFFFF, 3000));
    words_to_send.push_back(frame(1, 0, 1, 0, 0, 16'h8000, 0, 3000));
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph)
        0: program_regs(32767, 32767, 65535, 16383);
        1: program_regs(0, 0, 0, 0);
        2: program_regs(RST_MAX_HOR, RST_MAX_VER, RST_MAX_YAW, RST_DEAD_ZONE);
        5: program_regs($urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 65535), $urandom_range(0, 64));
        default: program_regs($urandom_range(0, 32767), $urandom_range(0, 32767),
                              $urandom_range(0, 65535), $urandom_range(0, 16383));
      endcase
      for (int n = 0; n < PhaseWords; n++) words_to_send.push_back(random_word());
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
